[rtl/alarm_table_clock_macros.svh]
// Assertion macros for the alarm table clock.
`ifndef ALARM_TABLE_CLOCK_MACROS_SVH
`define ALARM_TABLE_CLOCK_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ATC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ATC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/atc_pkg.sv]
// ----------------------------------------------------------------------------
// atc_pkg
// Shared types and constants of the alarm table clock.
// ----------------------------------------------------------------------------
`default_nettype none
package atc_pkg;
    localparam logic [2:0] MODE_IRQ    = 3'd0;
    localparam logic [2:0] MODE_UPTIME = 3'd1;
    localparam logic [2:0] MODE_GETTM  = 3'd2;
    localparam logic [2:0] MODE_SETTM  = 3'd3;
    localparam logic [2:0] MODE_ALARM  = 3'd4;
    localparam logic [2:0] MODE_SYNC   = 3'd5;
    localparam logic [31:0] NO_ALARM   = 32'hFFFF_FFFF;

    // Operations the controller asks of the datapath.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_TICK,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_SCAN_ENTRY,
        OP_RESULT,
        OP_ALARM_LEFT_START,
        OP_ALARM_WRITE,
        OP_EARLY_CLEAR,
        OP_EARLY_ENTRY
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [5:0] idx;
    } cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       due;
        logic       entry_fires;
        logic       more_due;
        logic       idx_bad;
        logic       old_live;
    } sts_t;
endpackage
`default_nettype wire

[rtl/atc_datapath.sv]
// ----------------------------------------------------------------------------
// atc_datapath
// Counters, alarm table, bit-serial divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module atc_datapath
    import atc_pkg::*;
#(
    parameter int NUM_ENTRIES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [9:0]  cfg_data,
    input  wire logic [88:0] in_data,
    input  wire cmd_t        cmd,
    input  wire logic        emit_last,
    output sts_t             sts,
    output logic [71:0]      res_data
);
    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    logic [9:0]  tps_reg;
    logic [31:0] tick_reg, secs_reg, boot_reg, early_reg;
    logic [31:0] alarm_reg [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] hflag_reg;
    logic [2:0]  mode_reg;
    logic [15:0] elap_reg;
    logic [3:0]  eidx_reg;
    logic [31:0] delta_reg, newt_reg;
    logic        hp_reg, task_reg;
    logic [31:0] quo_reg;
    logic [10:0] rem_reg;
    logic        div_sec_reg;
    logic [31:0] left_reg;
    logic [IW-1:0] cur;
    logic [IW-1:0] eidx_w;
    logic [31:0] cur_alarm;
    logic [9:0]  rate;
    logic [11:0] trial;
    logic [31:0] diff;
    logic        later_due;
    logic [71:0] res_next;

    assign rate = (tps_reg == 10'd0) ? 10'd1 : tps_reg;
    assign cur = cmd.idx[IW-1:0];
    assign eidx_w = IW'(eidx_reg);
    assign cur_alarm = alarm_reg[cur];
    assign trial = {rem_reg, quo_reg[31]} - {2'b00, rate};
    assign diff = alarm_reg[eidx_w] - tick_reg;

    // Another entry after the current one is due, so the current result is not last.
    always_comb
    begin
        later_due = 1'b0;
        for (int j = 0; j < NUM_ENTRIES; j++)
            if (j > int'(cur) && alarm_reg[j] != 32'd0 && alarm_reg[j] <= tick_reg)
                later_due = 1'b1;
    end

    assign sts.mode = mode_reg;
    assign sts.due = early_reg <= tick_reg;
    assign sts.entry_fires = (cur_alarm != 32'd0) && (cur_alarm <= tick_reg);
    assign sts.more_due = later_due;
    assign sts.idx_bad = {28'd0, eidx_reg} >= 32'(NUM_ENTRIES);
    assign sts.old_live = (alarm_reg[eidx_w] != 32'd0)
                        && (alarm_reg[eidx_w] > tick_reg);

    // Result word for the current request or fired entry.
    always_comb
    begin
        res_next = '0;
        res_next[71] = emit_last;
        if (mode_reg == MODE_IRQ)
        begin
            res_next[65] = 1'b1;
            res_next[69:66] = 4'(cur);
            res_next[70] = hflag_reg[cur];
        end
        else if (mode_reg == MODE_UPTIME)
            res_next[32:1] = tick_reg;
        else if (mode_reg == MODE_GETTM)
            res_next[32:1] = boot_reg + secs_reg;
        else if (mode_reg == MODE_ALARM)
        begin
            res_next[0] = sts.idx_bad;
            res_next[64:33] = left_reg;
        end
        else if (mode_reg > MODE_ALARM)
            res_next[0] = 1'b1;
    end

    // Control-state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg   <= 10'd100;
            tick_reg  <= '0;
            secs_reg  <= '0;
            boot_reg  <= '0;
            early_reg <= NO_ALARM;
            hflag_reg <= '0;
            for (int i = 0; i < NUM_ENTRIES; i++)
                alarm_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                tps_reg <= cfg_data;
            case (cmd.op)
                OP_TICK: tick_reg <= tick_reg + {16'd0, elap_reg};
                OP_RESULT:
                begin
                    if (mode_reg == MODE_IRQ)
                        alarm_reg[cur] <= '0;
                    if (mode_reg == MODE_SETTM)
                        boot_reg <= newt_reg - secs_reg;
                end
                OP_DIV_STEP:
                    if (cmd.idx == 6'd31 && div_sec_reg)
                        secs_reg <= {quo_reg[30:0], !trial[11]};
                OP_ALARM_WRITE:
                begin
                    alarm_reg[eidx_w] <= (delta_reg == 32'd0) ? 32'd0
                                         : tick_reg + delta_reg;
                    hflag_reg[eidx_w] <= hp_reg & task_reg;
                end
                OP_EARLY_CLEAR: early_reg <= NO_ALARM;
                OP_EARLY_ENTRY:
                    if (cur_alarm != 32'd0 && cur_alarm < early_reg)
                        early_reg <= cur_alarm;
                default: ;
            endcase
        end
    end

    // Payload registers: input latch, divider and result.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                mode_reg  <= in_data[2:0];
                elap_reg  <= in_data[18:3];
                eidx_reg  <= in_data[22:19];
                delta_reg <= in_data[54:23];
                newt_reg  <= in_data[86:55];
                hp_reg    <= in_data[87];
                task_reg  <= in_data[88];
                left_reg  <= '0;
            end
            OP_DIV_START:
            begin
                quo_reg <= tick_reg;
                rem_reg <= '0;
                div_sec_reg <= 1'b1;
            end
            OP_ALARM_LEFT_START:
            begin
                quo_reg <= diff - 32'd1;
                rem_reg <= '0;
                div_sec_reg <= 1'b0;
            end
            OP_DIV_STEP:
            begin
                if (trial[11])
                    rem_reg <= {rem_reg[9:0], quo_reg[31]};
                else
                    rem_reg <= trial[10:0];
                quo_reg <= {quo_reg[30:0], !trial[11]};
                if (cmd.idx == 6'd31 && !div_sec_reg)
                    left_reg <= {quo_reg[30:0], !trial[11]} + 32'd1;
            end
            OP_RESULT: res_data <= res_next;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

[rtl/atc_ctrl.sv]
// ----------------------------------------------------------------------------
// atc_ctrl
// Sequencer of one request: tick update, divide, per-mode work and results.
// ----------------------------------------------------------------------------
`default_nettype none
module atc_ctrl
    import atc_pkg::*;
#(
    parameter int NUM_ENTRIES = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_fire,
    input  wire logic out_free,
    input  wire sts_t sts,
    output logic      in_ready,
    output cmd_t      cmd,
    output logic      emit_last,
    output logic      out_load
);
    typedef enum logic [3:0] {
        S_IDLE, S_TICK, S_DSTART, S_DIV, S_DISPATCH, S_SCAN, S_EMIT,
        S_LSTART, S_LDIV, S_AWRITE, S_ECLR, S_EARLY, S_REPLY
    } state_t;

    state_t state_reg;
    logic [5:0] cnt_reg;

    always_comb
    begin
        cmd.op = OP_NONE;
        cmd.idx = cnt_reg;
        emit_last = 1'b0;
        out_load = 1'b0;
        in_ready = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:   if (in_fire) cmd.op = OP_LOAD;
            S_TICK:   cmd.op = OP_TICK;
            S_DSTART: cmd.op = OP_DIV_START;
            S_DIV, S_LDIV: cmd.op = OP_DIV_STEP;
            S_LSTART: cmd.op = OP_ALARM_LEFT_START;
            S_AWRITE: cmd.op = OP_ALARM_WRITE;
            S_ECLR:   cmd.op = OP_EARLY_CLEAR;
            S_EARLY:  cmd.op = OP_EARLY_ENTRY;
            S_EMIT:
                if (out_free)
                begin
                    cmd.op = OP_RESULT;
                    emit_last = !sts.more_due;
                    out_load = 1'b1;
                end
            S_REPLY:
                if (out_free)
                begin
                    cmd.op = OP_RESULT;
                    emit_last = 1'b1;
                    out_load = 1'b1;
                end
            default: ;
        endcase
    end

    // State and counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE: if (in_fire) state_reg <= S_TICK;
                S_TICK: state_reg <= S_DSTART;
                S_DSTART: begin cnt_reg <= '0; state_reg <= S_DIV; end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31) state_reg <= S_DISPATCH;
                end
                S_DISPATCH:
                begin
                    cnt_reg <= '0;
                    if (sts.mode == MODE_IRQ)
                        state_reg <= sts.due ? S_SCAN : S_IDLE;
                    else if (sts.mode == MODE_ALARM && !sts.idx_bad)
                        state_reg <= sts.old_live ? S_LSTART : S_AWRITE;
                    else
                        state_reg <= S_REPLY;
                end
                // A firing entry waits for room in the output register; it carries
                // last when no later entry is due.
                S_SCAN:
                begin
                    if (sts.entry_fires)
                        state_reg <= S_EMIT;
                    else if (cnt_reg == 6'(NUM_ENTRIES - 1))
                        state_reg <= S_ECLR;
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                S_EMIT:
                    if (out_free)
                    begin
                        if (cnt_reg == 6'(NUM_ENTRIES - 1))
                            state_reg <= S_ECLR;
                        else
                        begin
                            cnt_reg <= cnt_reg + 6'd1;
                            state_reg <= S_SCAN;
                        end
                    end
                S_LSTART: begin cnt_reg <= '0; state_reg <= S_LDIV; end
                S_LDIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31) state_reg <= S_AWRITE;
                end
                S_AWRITE: state_reg <= S_ECLR;
                S_ECLR: begin cnt_reg <= '0; state_reg <= S_EARLY; end
                S_EARLY:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(NUM_ENTRIES - 1))
                        state_reg <= (sts.mode == MODE_IRQ) ? S_IDLE : S_REPLY;
                end
                S_REPLY: if (out_free) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/alarm_table_clock.sv]
// ----------------------------------------------------------------------------
// alarm_table_clock
// System tick clock with a table of one-shot alarms.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the s_axis channel, one transfer each; results
// leave on m_axis, tlast on the final result of a request. An interrupt
// request that finds nothing due gives no transfer.
// After the accepting edge a request goes through the tick update and the
// 32-step seconds divider. A read, set-time or error request then loads its
// result into the output register when there is room, and the next request
// can be accepted after that. Set alarm adds the remaining-time divide when
// an alarm was pending, the table write and the earliest-alarm pass over all
// entries. A due interrupt adds a scan of the entries, an emit for each fired
// entry, the clearing of the earliest alarm and the earliest-alarm pass.
// One request is worked at a time; s_axis_tready is high only when idle.
// Reset empties the table, clears the counters and sets the tick rate to
// 100. A stalled receiver holds the output register and the scan waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "alarm_table_clock_macros.svh"
module alarm_table_clock
    import atc_pkg::*;
#(
    parameter int NUM_ENTRIES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [9:0]  cfg_data,       // ticks_per_second
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // mode, elapsed_ticks, entry_index, alarm delay, new_time,
    // handler_present, entry_is_task
    input  wire logic [95:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status, time_value, remaining seconds, fired_valid, fired_entry,
    // fired_by_handler
    output logic [71:0]      m_axis_tdata,
    output logic             m_axis_tlast
);
    cmd_t cmd;
    sts_t sts;
    logic emit_last, out_load, in_fire, out_free;
    logic [71:0] res_data;
    logic valid_reg;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_free = !valid_reg || m_axis_tready;

    atc_ctrl #(.NUM_ENTRIES(NUM_ENTRIES)) u_ctrl (
        .clk, .rst_n, .in_fire, .out_free, .sts,
        .in_ready(s_axis_tready), .cmd, .emit_last, .out_load
    );

    atc_datapath #(.NUM_ENTRIES(NUM_ENTRIES)) u_dp (
        .clk, .rst_n, .cfg_we, .cfg_data, .in_data(s_axis_tdata[88:0]),
        .cmd, .emit_last, .sts, .res_data
    );

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (out_load)
            valid_reg <= 1'b1;
        else if (m_axis_tready)
            valid_reg <= 1'b0;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {1'b0, res_data[70:0]};
    assign m_axis_tlast  = res_data[71];

    `ATC_ASSERT_IMP(a_no_overrun, m_axis_tvalid && !m_axis_tready, !out_load)
    `ATC_ASSERT_NEXT(a_load_valid, out_load, m_axis_tvalid)
endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the alarm table clock: a directed table of
// requests, then random request streams under several tick rates and
// handshake idling patterns, results checked against a model or typed rows.
// ----------------------------------------------------------------------------
module tb;
    import atc_pkg::*;

    localparam int ENTRIES   = 16;
    localparam int DRAIN_CYC = 300;

    typedef struct {
        logic [2:0]  mode;
        logic [15:0] elapsed;
        logic [3:0]  idx;
        logic [31:0] delta;
        logic [31:0] newt;
        logic        hpres;
        logic        istask;
    } req_t;

    typedef struct {
        logic        status;
        logic [31:0] tv;
        logic [31:0] sl;
        logic        fv;
        logic [3:0]  fe;
        logic        fh;
        logic        last;
    } rsp_t;

    // A directed row; typed rows carry a single result read off by hand.
    typedef struct {
        req_t        req;
        bit          typed;
        logic        status;
        logic [31:0] tv;
        logic [31:0] sl;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [9:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;

    // Model state of the clock.
    logic [9:0]  tick_rate;
    logic [31:0] ticks;
    logic [31:0] up_secs;
    logic [31:0] boot_secs;
    logic [31:0] alarm_at [ENTRIES];
    logic        use_handler [ENTRIES];
    logic [31:0] soonest_alarm;

    rsp_t pending_rsp [$];
    int   error_count;
    int   sender_idle;
    int   receiver_stall;

    alarm_table_clock u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [95:0] pack_req(req_t r);
        return {7'd0, r.istask, r.hpres, r.newt, r.delta, r.idx, r.elapsed, r.mode};
    endfunction

    function automatic rsp_t make_rsp(logic st, logic [31:0] tv, logic [31:0] sl,
                                      logic fv, logic [3:0] fe, logic fh, logic last);
        rsp_t r;
        r.status = st;
        r.tv     = tv;
        r.sl     = sl;
        r.fv     = fv;
        r.fe     = fe;
        r.fh     = fh;
        r.last   = last;
        return r;
    endfunction

    function automatic logic [31:0] eff_rate();
        return (tick_rate == 10'd0) ? 32'd1 : {22'd0, tick_rate};
    endfunction

    task automatic rescan_earliest();
        soonest_alarm = NO_ALARM;
        for (int i = 0; i < ENTRIES; i++)
            if (alarm_at[i] != 0 && alarm_at[i] < soonest_alarm)
                soonest_alarm = alarm_at[i];
    endtask

    // Advances the model by one request and queues the results it gives.
    task automatic serve_request(req_t r);
        logic [63:0] diff;
        logic [31:0] left;
        int          first;
        first = pending_rsp.size();
        ticks   = ticks + {16'd0, r.elapsed};
        up_secs = ticks / eff_rate();
        case (r.mode)
            MODE_IRQ:
            begin
                if (soonest_alarm <= ticks)
                begin
                    soonest_alarm = NO_ALARM;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (alarm_at[i] != 0 && alarm_at[i] <= ticks)
                        begin
                            pending_rsp.push_back(make_rsp(1'b0, 0, 0, 1'b1, i[3:0],
                                                           use_handler[i], 1'b0));
                            alarm_at[i] = 0;
                        end
                        if (alarm_at[i] != 0 && alarm_at[i] < soonest_alarm)
                            soonest_alarm = alarm_at[i];
                    end
                    if (pending_rsp.size() > first)
                        pending_rsp[pending_rsp.size() - 1].last = 1'b1;
                end
            end
            MODE_UPTIME: pending_rsp.push_back(make_rsp(1'b0, ticks, 0, 0, 0, 0, 1'b1));
            MODE_GETTM:
                pending_rsp.push_back(make_rsp(1'b0, boot_secs + up_secs, 0, 0, 0, 0, 1'b1));
            MODE_SETTM:
            begin
                boot_secs = r.newt - up_secs;
                pending_rsp.push_back(make_rsp(1'b0, 0, 0, 0, 0, 0, 1'b1));
            end
            MODE_ALARM:
            begin
                left = 0;
                if (alarm_at[r.idx] != 0 && alarm_at[r.idx] > ticks)
                begin
                    diff = {32'd0, alarm_at[r.idx] - ticks};
                    diff = (diff + eff_rate() - 1) / eff_rate();
                    left = diff[31:0];
                end
                alarm_at[r.idx]    = (r.delta == 0) ? 32'd0 : ticks + r.delta;
                use_handler[r.idx] = r.hpres & r.istask;
                rescan_earliest();
                pending_rsp.push_back(make_rsp(1'b0, 0, left, 0, 0, 0, 1'b1));
            end
            default: pending_rsp.push_back(make_rsp(1'b1, 0, 0, 0, 0, 0, 1'b1));
        endcase
    endtask

    // Presents one request and waits for its transfer.
    task automatic send_request(req_t r);
        while ($urandom_range(99) < sender_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_req(r);
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic idle_pause();
        s_axis_tvalid <= 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_rate(logic [9:0] v);
        idle_pause();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tick_rate  = v;
    endtask

    function automatic req_t random_request();
        req_t r;
        int   pick;
        r.mode    = 3'($urandom_range(7));
        r.elapsed = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(300));
        r.idx     = 4'($urandom_range(15));
        r.delta   = $urandom;
        r.newt    = $urandom;
        r.hpres   = 1'($urandom);
        r.istask  = 1'($urandom);
        pick      = $urandom_range(99);
        if (pick < 35)
        begin
            r.mode = MODE_ALARM;
            pick   = $urandom_range(9);
            if (pick < 7)
                r.delta = $urandom_range(1, 600);
            else if (pick == 7)
                r.delta = 0;
            else if (pick == 8)
                r.delta = 32'd0 - ticks - r.elapsed;
        end
        else if (pick < 65)
            r.mode = MODE_IRQ;
        else if (pick < 73)
            r.mode = MODE_UPTIME;
        else if (pick < 81)
            r.mode = MODE_GETTM;
        else if (pick < 88)
            r.mode = MODE_SETTM;
        return r;
    endfunction

    // Result checking.
    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = make_rsp(m_axis_tdata[0], m_axis_tdata[32:1], m_axis_tdata[64:33],
                           m_axis_tdata[65], m_axis_tdata[69:66], m_axis_tdata[70],
                           m_axis_tlast);
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected result, actual %p", $realtime, got);
                error_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $realtime,
                             want.status, got.status);
                    error_count++;
                end
                if (got.tv !== want.tv)
                begin
                    $display("%0t: time_value expected %0h actual %0h", $realtime,
                             want.tv, got.tv);
                    error_count++;
                end
                if (got.sl !== want.sl)
                begin
                    $display("%0t: remaining seconds expected %0h actual %0h", $realtime,
                             want.sl, got.sl);
                    error_count++;
                end
                if (got.fv !== want.fv)
                begin
                    $display("%0t: fired_valid expected %0d actual %0d", $realtime,
                             want.fv, got.fv);
                    error_count++;
                end
                if (got.fe !== want.fe)
                begin
                    $display("%0t: fired_entry expected %0d actual %0d", $realtime,
                             want.fe, got.fe);
                    error_count++;
                end
                if (got.fh !== want.fh)
                begin
                    $display("%0t: fired_by_handler expected %0d actual %0d", $realtime,
                             want.fh, got.fh);
                    error_count++;
                end
                if (got.last !== want.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $realtime,
                             want.last, got.last);
                    error_count++;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall);
    end

    function automatic row_t mk_row(logic [2:0] m, logic [15:0] el, logic [3:0] ix,
                                    logic [31:0] dl, logic [31:0] nt, logic hp, logic tk,
                                    bit typed, logic st, logic [31:0] tv, logic [31:0] sl);
        row_t w;
        w.req.mode    = m;
        w.req.elapsed = el;
        w.req.idx     = ix;
        w.req.delta   = dl;
        w.req.newt    = nt;
        w.req.hpres   = hp;
        w.req.istask  = tk;
        w.typed       = typed;
        w.status      = st;
        w.tv          = tv;
        w.sl          = sl;
        return w;
    endfunction

    // Stimulus.
    initial
    begin
        row_t rows [$];
        req_t r;
        int   want_size;
        rsp_t typed_rsp;
        logic [9:0] rates [4];
        int   idles [4];
        int   stalls [4];

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = 10'd0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        error_count    = 0;
        sender_idle    = 0;
        receiver_stall = 0;
        tick_rate      = 10'd100;
        ticks          = 0;
        up_secs        = 0;
        boot_secs      = 0;
        soonest_alarm  = NO_ALARM;
        for (int i = 0; i < ENTRIES; i++)
        begin
            alarm_at[i]    = 0;
            use_handler[i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: reset reads, bad modes, set time, arm, replace,
        // wrap to zero, expiry with and without handler, cancel, overdue.
        rows.push_back(mk_row(MODE_UPTIME, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        rows.push_back(mk_row(MODE_GETTM, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        rows.push_back(mk_row(MODE_IRQ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_SYNC, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0));
        rows.push_back(mk_row(3'd6, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0));
        rows.push_back(mk_row(3'd7, 0, 15, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1, 1, 1, 0, 0));
        rows.push_back(mk_row(MODE_SETTM, 16'hFFFF, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_GETTM, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_ALARM, 0, 0, 1000, 0, 1, 1, 1, 0, 0, 0));
        rows.push_back(mk_row(MODE_ALARM, 0, 15, 32'hFFFFFFFF, 0, 1, 0, 1, 0, 0, 0));
        rows.push_back(mk_row(MODE_ALARM, 0, 0, 50, 0, 1, 1, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_ALARM, 0, 3, 32'hFFFF0001, 0, 1, 1, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_IRQ, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_ALARM, 0, 15, 5, 0, 0, 1, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_ALARM, 0, 7, 1, 0, 0, 1, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_ALARM, 0, 9, 2, 0, 1, 1, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_IRQ, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_ALARM, 0, 2, 10, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_IRQ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_ALARM, 0, 2, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_ALARM, 0, 4, 3, 0, 1, 1, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_UPTIME, 10, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_ALARM, 0, 4, 7, 0, 1, 1, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_IRQ, 20, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        foreach (rows[k])
        begin
            send_request(rows[k].req);
            want_size = pending_rsp.size();
            serve_request(rows[k].req);
            if (rows[k].typed)
            begin
                typed_rsp = make_rsp(rows[k].status, rows[k].tv, rows[k].sl, 0, 0, 0, 1'b1);
                pending_rsp[want_size] = typed_rsp;
            end
        end

        // Random phases, each under its own tick rate and idling pattern.
        rates  = '{10'd1000, 10'd1, 10'd0, 10'($urandom_range(1, 1000))};
        idles  = '{0, 81, 0, 30};
        stalls = '{0, 0, 81, 30};
        for (int p = 0; p < 4; p++)
        begin
            write_rate(rates[p]);
            sender_idle    = idles[p];
            receiver_stall = stalls[p];
            for (int n = 0; n < 60; n++)
            begin
                // Let the block drain completely once mid-run.
                if (p == 1 && n == 40)
                    idle_pause();
                // Occasionally arm a burst of short alarms so many fire together.
                if ($urandom_range(59) == 0)
                begin
                    for (int e = 0; e < ENTRIES; e++)
                    begin
                        r = random_request();
                        r.mode    = MODE_ALARM;
                        r.idx     = e[3:0];
                        r.elapsed = 0;
                        r.delta   = $urandom_range(1, 40);
                        send_request(r);
                        serve_request(r);
                    end
                end
                r = random_request();
                send_request(r);
                serve_request(r);
            end
        end

        // Drain and finish.
        s_axis_tvalid <= 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (DRAIN_CYC) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/atc_pkg.sv
rtl/atc_datapath.sv
rtl/atc_ctrl.sv
rtl/alarm_table_clock.sv
dv/tb.sv
